@@ sv/assert_macros.svh @@
// Assertion helpers included by the arbiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge of clock outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Checks that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ sv/bta_pkg.sv @@
// ----------------------------------------------------------------------------
// bta_pkg: types and constants of the bakery ticket arbiter
// Item layouts, table sizes, action and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bta_pkg;

   // Table geometry.
   localparam int MAX_JOBS    = 16;
   localparam int TICKET_BITS = 8;
   localparam int JOB_W       = $clog2(MAX_JOBS);
   localparam int CNT_W       = $clog2(MAX_JOBS + 1);

   // Fixed field widths of the channels.
   localparam int ID_W     = 4;
   localparam int OUT_TK_W = 8;
   localparam int CSR_W    = 5;
   localparam int CSR_RESET = 16;

   typedef logic [TICKET_BITS-1:0] ticket_type;

   // Largest ticket value; a request past it saturates.
   localparam ticket_type TICKET_TOP = {TICKET_BITS{1'b1}};

   typedef enum logic {
      ACTION_REQUEST = 1'b0,
      ACTION_RELEASE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_SAT   = 2'd2
   } status_type;

   typedef struct packed {
      action_type      action;
      logic [ID_W-1:0] job_id;
   } req_item_type;

   typedef struct packed {
      logic [OUT_TK_W-1:0] ticket_given;
      logic                holder_valid;
      logic [ID_W-1:0]     holder_id;
      logic [OUT_TK_W-1:0] holder_ticket;
      status_type          status;
   } rsp_item_type;

endpackage

@@ sv/bakery_ticket_arbiter.sv @@
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter: ticket-ordered mutual-exclusion arbiter
// Job tickets live in a small synchronous RAM; one scan per item finds the
// largest ticket and the smallest other ticket, then the entry is updated.
// ----------------------------------------------------------------------------
//
//  channel   ports                       handshake
//  -------   -------------------------   -------------------------------
//  request   start, busy, req_item       taken when start and not busy
//  result    rsp_strobe, rsp_item        one cycle, cannot be stalled
//  config    csr_we, csr_wdata           written when csr_we is high
//
// Each item passes through ST_SCAN, which streams all MAX_JOBS RAM entries
// through the one read port, and ST_FINISH, which writes the entry back and
// registers the result. The result strobe is high in the idle cycle after
// that, at whose end the next item can be taken; until then the block is
// busy. Reset and a configuration write clear the valid bits of the table
// at once, so no clearing pass is needed. No backpressure on results.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bakery_ticket_arbiter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  bta_pkg::req_item_type     req_item,
   output logic                      rsp_strobe,
   output bta_pkg::rsp_item_type     rsp_item,
   input  logic                      csr_we,
   input  logic [bta_pkg::CSR_W-1:0] csr_wdata
);
   import bta_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [JOB_W-1:0]   pend_idx_ff;
   logic [CSR_W-1:0]   active_ff;
   logic [MAX_JOBS-1:0] valid_ff;

   // Ticket store and its registered read data.
   ticket_type         ticket_mem_ff [MAX_JOBS];
   ticket_type         rdata_ff;

   // Captured item and scan accumulators.
   action_type         act_ff;
   logic [ID_W-1:0]    who_ff;
   logic               in_range_ff;
   ticket_type         max_ff, max_in;
   logic               found_ff, found_in;
   ticket_type         best_ff, best_in;
   logic [JOB_W-1:0]   best_id_ff, best_id_in;

   logic               rsp_strobe_ff;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic               accept;
   logic [7:0]         live_n;
   logic               in_range;
   ticket_type         entry;
   logic               scan_done;
   ticket_type         given;
   status_type         status;
   logic               take_self;
   logic               mem_we;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // Number of live slots, capped at the table depth.
   always_comb begin
      if (8'(active_ff) > 8'(MAX_JOBS)) begin
         live_n = 8'(MAX_JOBS);
      end else begin
         live_n = 8'(active_ff);
      end
      in_range = (8'(req_item.job_id) < live_n);
   end

   // An entry whose valid bit is clear reads as zero.
   assign entry     = valid_ff[pend_idx_ff] ? rdata_ff : '0;
   assign scan_done = (cnt_ff == CNT_W'(MAX_JOBS));

   // Scan control: issue one read a cycle, accumulate one entry a cycle.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pend_in    = 1'b0;
      max_in     = max_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      best_id_in = best_id_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               max_in   = '0;
               found_in = 1'b0;
               best_in  = '0;
               best_id_in = '0;
            end
         end
         ST_SCAN: begin
            if (!scan_done) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
            if (pend_ff) begin
               if (entry > max_ff) begin
                  max_in = entry;
               end
               // The job's own entry is replaced, so it is left out here.
               if ((entry != '0) &&
                   !(in_range_ff && (pend_idx_ff == JOB_W'(who_ff))) &&
                   (!found_ff || (entry < best_ff))) begin
                  found_in   = 1'b1;
                  best_in    = entry;
                  best_id_in = pend_idx_ff;
               end
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // New ticket, status and holder at the end of the scan.
   always_comb begin
      given  = '0;
      status = STATUS_OK;
      if (!in_range_ff) begin
         status = STATUS_RANGE;
      end else if (act_ff == ACTION_REQUEST) begin
         if (max_ff == TICKET_TOP) begin
            given  = TICKET_TOP;
            status = STATUS_SAT;
         end else begin
            given = max_ff + ticket_type'(1);
         end
      end
      // The requesting job wins against the best of the others on a lower
      // ticket, or on an equal ticket with a lower job number.
      take_self = in_range_ff && (act_ff == ACTION_REQUEST) &&
                  (!found_ff || (given < best_ff) ||
                   ((given == best_ff) && (JOB_W'(who_ff) < best_id_ff)));
      rsp_item_in.ticket_given = OUT_TK_W'(given);
      rsp_item_in.status       = status;
      rsp_item_in.holder_valid = found_ff || take_self;
      if (take_self) begin
         rsp_item_in.holder_id     = who_ff;
         rsp_item_in.holder_ticket = OUT_TK_W'(given);
      end else if (found_ff) begin
         rsp_item_in.holder_id     = ID_W'(best_id_ff);
         rsp_item_in.holder_ticket = OUT_TK_W'(best_ff);
      end else begin
         rsp_item_in.holder_id     = '0;
         rsp_item_in.holder_ticket = '0;
      end
      mem_we = (state_ff == ST_FINISH) && in_range_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         active_ff     <= CSR_W'(CSR_RESET);
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= (state_ff == ST_FINISH);
         if (csr_we) begin
            // A new job set starts with nobody waiting.
            active_ff <= csr_wdata;
            valid_ff  <= '0;
         end else if (mem_we) begin
            valid_ff[JOB_W'(who_ff)] <= (act_ff == ACTION_REQUEST);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_idx_ff <= cnt_ff[JOB_W-1:0];
      max_ff      <= max_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_id_ff  <= best_id_in;
      if (accept) begin
         act_ff      <= req_item.action;
         who_ff      <= req_item.job_id;
         in_range_ff <= in_range;
      end
      if (state_ff == ST_FINISH) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // Ticket RAM: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we && (act_ff == ACTION_REQUEST)) begin
         ticket_mem_ff[JOB_W'(who_ff)] <= given;
      end
      rdata_ff <= ticket_mem_ff[cnt_ff[JOB_W-1:0]];
   end

   // Checks on sequencing and result consistency.
   `ASSERT_NEXT(a_accept_starts_scan, accept,
                (state_ff == ST_SCAN) && (cnt_ff == '0), "scan did not start")
   `ASSERT_IMPLY(a_strobe_when_idle, rsp_strobe, !busy, "result shown while busy")
   `ASSERT_IMPLY(a_holder_nonzero, rsp_strobe && rsp_item.holder_valid,
                 rsp_item.holder_ticket != '0, "holder with zero ticket")
   `ASSERT_IMPLY(a_sat_top, rsp_strobe && (rsp_item.status == STATUS_SAT),
                 rsp_item.ticket_given == OUT_TK_W'(TICKET_TOP), "saturated ticket not at top")

endmodule

@@ dv/bakery_ticket_arbiter_test.sv @@
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter_test: self-checking testbench of the ticket arbiter
// Drives request and release items through the command port, with
// reconfiguration of the active job count between phases. A scoreboard
// class keeps its own ticket table and predicts every result item, which
// is then compared field by field with what the block reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Scoreboard: mirrors the ticket table and checks each reported result item.
class bakery_scoreboard;

   bta_pkg::ticket_type   tickets [bta_pkg::MAX_JOBS];
   logic [bta_pkg::CSR_W-1:0] job_count;
   bta_pkg::rsp_item_type expected_grants [$];
   int                    failures;

   function new();
      job_count = bta_pkg::CSR_W'(bta_pkg::CSR_RESET);
      failures  = 0;
      foreach (tickets[k]) tickets[k] = '0;
   endfunction

   // A write of the job count starts a fresh set of jobs with no tickets.
   function void set_jobs(logic [bta_pkg::CSR_W-1:0] value);
      job_count = value;
      foreach (tickets[k]) tickets[k] = '0;
   endfunction

   function int pending();
      return expected_grants.size();
   endfunction

   // Works out the grant that one item causes and updates the table.
   function bta_pkg::rsp_item_type predict_grant(bta_pkg::req_item_type it);
      bta_pkg::rsp_item_type grant;
      bta_pkg::ticket_type   top;
      int                    live;
      bit                    found;
      live  = (job_count > bta_pkg::MAX_JOBS) ? bta_pkg::MAX_JOBS : int'(job_count);
      grant = '0;
      grant.status = bta_pkg::STATUS_OK;
      if (int'(it.job_id) >= live) begin
         grant.status = bta_pkg::STATUS_RANGE;
      end else if (it.action == bta_pkg::ACTION_REQUEST) begin
         top = '0;
         for (int k = 0; k < live; k++)
            if (tickets[k] > top) top = tickets[k];
         // A full ticket counter holds at its top value.
         if (top == bta_pkg::TICKET_TOP) begin
            grant.ticket_given = bta_pkg::TICKET_TOP;
            grant.status       = bta_pkg::STATUS_SAT;
         end else begin
            grant.ticket_given = top + bta_pkg::ticket_type'(1);
         end
         tickets[it.job_id] = grant.ticket_given;
      end else begin
         tickets[it.job_id] = '0;
      end

      // Holder: smallest nonzero ticket, lower job number wins a tie.
      found = 1'b0;
      for (int k = 0; k < live; k++) begin
         if (tickets[k] != 0 && (!found || tickets[k] < grant.holder_ticket)) begin
            found               = 1'b1;
            grant.holder_ticket = tickets[k];
            grant.holder_id     = k[bta_pkg::ID_W-1:0];
         end
      end
      grant.holder_valid = found;
      return grant;
   endfunction

   function void note_item(bta_pkg::req_item_type it);
      expected_grants.push_back(predict_grant(it));
   endfunction

   function void check_result(bta_pkg::rsp_item_type got);
      bta_pkg::rsp_item_type want;
      if (expected_grants.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected result item: given=%0d valid=%0d id=%0d ticket=%0d %s%0d",
                     got.ticket_given, got.holder_valid, got.holder_id,
                     got.holder_ticket, "status=", got.status);
         return;
      end
      want = expected_grants.pop_front();
      if (got.ticket_given !== want.ticket_given ||
          got.holder_valid !== want.holder_valid ||
          got.holder_id !== want.holder_id || got.holder_ticket !== want.holder_ticket ||
          got.status !== want.status) begin
         failures++;
         if (failures <= 10) begin
            $display("result mismatch: expected given=%0d valid=%0d id=%0d ticket=%0d %s%0d",
                     want.ticket_given, want.holder_valid, want.holder_id,
                     want.holder_ticket, "status=", want.status);
            $display("                 actual   given=%0d valid=%0d id=%0d ticket=%0d %s%0d",
                     got.ticket_given, got.holder_valid, got.holder_id,
                     got.holder_ticket, "status=", got.status);
         end
      end
   endfunction

endclass

module bakery_ticket_arbiter_test;

   import bta_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;
   logic         csr_we;
   logic [CSR_W-1:0] csr_wdata;

   bakery_scoreboard sb;
   int idle_pct;
   int cycle_count;

   bakery_ticket_arbiter DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bakery_ticket_arbiter_test: done, errors");
         $finish;
      end
   end

   // Monitor: note accepted items and check every result item.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_item(req_item);
         if (rsp_strobe) sb.check_result(rsp_item);
      end
   end

   // Offers one item after a random idle gap and returns once the block is no longer busy.
   task automatic send_item(action_type act, int job);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_item.action <= act;
      req_item.job_id <= job[ID_W-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Waits until the block is quiet, then writes the job count.
   task automatic write_jobs(int value);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value[CSR_W-1:0];
      sb.set_jobs(value[CSR_W-1:0]);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One random phase. In climb mode job 0 never releases, so the largest
   // ticket never drops below job 0's and the counter is driven into saturation.
   task automatic run_phase(int jobs, int idle, int count, int rel_pct, bit climb);
      int         live;
      int         job;
      action_type act;
      live = (jobs > MAX_JOBS) ? MAX_JOBS : jobs;
      write_jobs(jobs);
      idle_pct = idle;
      for (int i = 0; i < count; i++) begin
         if (live > 0 && $urandom_range(99) < 90) job = $urandom_range(live - 1);
         else job = $urandom_range(15);
         act = ($urandom_range(99) < rel_pct) ? ACTION_RELEASE : ACTION_REQUEST;
         if (climb && job == 0) act = ACTION_REQUEST;
         send_item(act, job);
      end
   endtask

   initial begin
      sb          = new();
      idle_pct    = 0;
      cycle_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: full job count out of reset.
      send_item(ACTION_REQUEST, 0);
      send_item(ACTION_REQUEST, 15);
      send_item(ACTION_REQUEST, 15);   // own ticket counts toward the top
      send_item(ACTION_RELEASE, 0);
      send_item(ACTION_RELEASE, 15);   // nobody waiting afterwards
      send_item(ACTION_RELEASE, 7);    // release without a ticket
      send_item(ACTION_REQUEST, 8);
      send_item(ACTION_REQUEST, 3);

      // Directed: small job count, ids past it are flagged.
      write_jobs(4);
      send_item(ACTION_REQUEST, 5);
      send_item(ACTION_REQUEST, 3);
      send_item(ACTION_RELEASE, 15);
      send_item(ACTION_REQUEST, 0);

      // Directed: no active jobs at all.
      write_jobs(0);
      send_item(ACTION_REQUEST, 0);
      send_item(ACTION_RELEASE, 0);

      // Directed: a job count above the table size acts as the table size.
      write_jobs(31);
      send_item(ACTION_REQUEST, 15);
      send_item(ACTION_REQUEST, 0);
      send_item(ACTION_RELEASE, 15);

      // Directed: a single job.
      write_jobs(1);
      send_item(ACTION_REQUEST, 0);
      send_item(ACTION_REQUEST, 1);
      send_item(ACTION_RELEASE, 0);

      // Random phases with mixed job counts and idling.
      run_phase(16, 0, 150, 40, 1'b0);
      run_phase(2, 79, 320, 10, 1'b1);
      run_phase(7, 12, 200, 35, 1'b0);
      run_phase($urandom_range(1, 16), 79, 150, 30, 1'b0);
      run_phase($urandom_range(1, 16), 0, 150, 45, 1'b0);
      run_phase(0, 12, 20, 50, 1'b0);
      run_phase(31, 0, 100, 30, 1'b0);

      // Let the last result item arrive, then report.
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("bakery_ticket_arbiter_test: done, clean");
      end else begin
         $display("bakery_ticket_arbiter_test: done, errors");
      end
      $finish;
   end

endmodule
